### hdl/dqd_pkg.sv
// Package for the deadline queue dispatcher: payload structs, sizes and controller interface types.
// Used by dqd_ctrl, dqd_datapath and deadline_queue_dispatcher; depends on nothing.
package dqd_pkg;

	localparam int QueueDepth = 3;
	localparam int MaxServers = 2;
	localparam int TimeWidth = 24;
	localparam int SlotCount = MaxServers * QueueDepth;
	localparam int SlotWidth = $clog2(SlotCount);
	localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CountWidth = $clog2(QueueDepth + 1);
	localparam int SrvWidth = (MaxServers > 1) ? $clog2(MaxServers) : 1;

	localparam logic CMD_JOB = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;
	localparam logic KIND_ABORT = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	typedef logic [TimeWidth-1:0] time_t;

	typedef struct packed {
		logic cmd;
		logic [15:0] order_id;
		logic [23:0] arrival;
		logic [23:0] duration;
		logic [23:0] deadline;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [15:0] job_id;
		logic [1:0] server;
		logic [23:0] delay;
		logic [23:0] event_time;
		logic last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic read_head;
		logic pop;
		logic place;
		logic reject;
		logic emit;
		logic emit_last;
		logic [SrvWidth-1:0] srv;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_flush;
		logic dropped;
		logic can_serve;
		logic pop_emits;
		logic out_busy;
		logic single;
	} dp_stat_t;

endpackage

### hdl/deadline_queue_dispatcher.sv
// Deadline queue dispatcher top level: controller plus datapath with valid/stall channels.
// Per item the controller checks servers and starts due queued jobs, then places the job;
// a flush only drains the queues, and a job past its deadline goes straight to the end. Output stalls hold it.
// The last record of an item leaves as the controller goes idle; others trail by one record.
// arst_n clears queues, free times and sets cnt_cfg_q to 2; queue storage is not cleared.
// Depends on dqd_pkg, dqd_ctrl and dqd_datapath.
module deadline_queue_dispatcher (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input dqd_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output dqd_pkg::out_item_t out_data
);

	dqd_pkg::dp_cmd_t cmd;
	dqd_pkg::dp_stat_t stat;
	logic ready;

	assign in_stall = !ready;

	dqd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(ready),
		.stat(stat),
		.cmd(cmd)
	);

	dqd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

### hdl/dqd_ctrl.sv
// Controller state machine of the dispatcher: sequences serving, placement and record output.
// Depends on dqd_pkg; drives dqd_datapath through dp_cmd_t and reads dp_stat_t.
module dqd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dqd_pkg::dp_stat_t stat,
	output dqd_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_POP = 3'd3;
	localparam logic [2:0] ST_PLACE = 3'd4;
	localparam logic [2:0] ST_LAST = 3'd5;

	logic [2:0] state_q, state_d;
	logic [dqd_pkg::SrvWidth-1:0] srv_q, srv_d;
	logic pend_q, pend_d;
	logic srv_done;
	logic [dqd_pkg::SrvWidth:0] srv_lim;

	assign srv_lim = (stat.is_flush || !stat.single) ?
		(dqd_pkg::SrvWidth+1)'(dqd_pkg::MaxServers) : (dqd_pkg::SrvWidth+1)'(1);
	assign srv_done = ((dqd_pkg::SrvWidth+1)'(srv_q) + 1'b1) >= srv_lim;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		srv_d = srv_q;
		pend_d = pend_q;
		cmd = '0;
		cmd.srv = srv_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					srv_d = '0;
					pend_d = 1'b0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.out_busy) begin
					state_d = ST_CHECK;
				end else if (!stat.is_flush && stat.dropped) begin
					state_d = ST_LAST;
				end else if (stat.can_serve) begin
					state_d = ST_READ;
				end else if (!srv_done) begin
					srv_d = srv_q + 1'b1;
				end else if (stat.is_flush) begin
					state_d = ST_LAST;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_READ: begin
				cmd.read_head = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				if (!stat.out_busy) begin
					cmd.pop = 1'b1;
					if (stat.pop_emits) begin
						cmd.emit = 1'b1;
						pend_d = 1'b1;
					end
					state_d = ST_CHECK;
				end
			end
			ST_PLACE: begin
				if (!stat.out_busy) begin
					cmd.place = 1'b1;
					if (stat.dropped) begin
						cmd.reject = 1'b1;
						cmd.emit = 1'b1;
						pend_d = 1'b1;
					end
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (!stat.out_busy) begin
					if (pend_q) begin
						cmd.emit_last = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			srv_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			srv_q <= srv_d;
			pend_q <= pend_d;
		end
	end

	a_place_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |-> ($past(state_q) == ST_CHECK || $past(state_q) == ST_PLACE))
		else $error("placement not entered from check");
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_POP))
		else $error("head read not followed by pop");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready)
		else $error("load outside idle");

endmodule

### hdl/dqd_datapath.sv
// Datapath of the dispatcher: queues, free times, placement choice and the output register.
// Depends on dqd_pkg; commanded by dqd_ctrl.
module dqd_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_data,
	input dqd_pkg::in_item_t in_data,
	input dqd_pkg::dp_cmd_t cmd,
	output dqd_pkg::dp_stat_t stat,
	output logic out_valid,
	input logic out_stall,
	output dqd_pkg::out_item_t out_data
);

	localparam int TW = dqd_pkg::TimeWidth;
	localparam int SW = dqd_pkg::SrvWidth;
	localparam int CW = dqd_pkg::CountWidth;
	localparam int PW = dqd_pkg::PtrWidth;
	localparam int LW = dqd_pkg::SlotWidth;

	logic [1:0] cnt_cfg_q;
	dqd_pkg::in_item_t job_q;
	dqd_pkg::time_t free_q [dqd_pkg::MaxServers];
	logic [PW-1:0] head_q [dqd_pkg::MaxServers];
	logic [CW-1:0] count_q [dqd_pkg::MaxServers];
	logic [15:0] mem_id [dqd_pkg::SlotCount];
	dqd_pkg::time_t mem_arr [dqd_pkg::SlotCount];
	dqd_pkg::time_t mem_dur [dqd_pkg::SlotCount];
	dqd_pkg::time_t mem_dl [dqd_pkg::SlotCount];
	logic [15:0] hd_id_q;
	dqd_pkg::time_t hd_arr_q, hd_dur_q, hd_dl_q;
	logic out_valid_q;
	dqd_pkg::out_item_t out_q;
	logic pend_valid_q;
	dqd_pkg::out_item_t pend_q;

	logic single;
	logic [TW:0] job_sum, pop_sum;
	dqd_pkg::time_t cur_free, new_free, pop_delay;
	logic pop_abort, pop_timeout;
	logic [LW-1:0] head_slot, tail_slot;
	logic [SW-1:0] pick;
	logic pick_ok;
	logic [CW-1:0] best_cnt;
	dqd_pkg::out_item_t rec;
	dqd_pkg::out_item_t pend_out;

	assign single = (cnt_cfg_q != 2'd2) && (cnt_cfg_q != 2'd3) || (dqd_pkg::MaxServers == 1);
	assign job_sum = {1'b0, job_q.arrival} + {1'b0, job_q.duration};
	assign cur_free = free_q[cmd.srv];
	assign pop_sum = {1'b0, cur_free} + {1'b0, hd_dur_q};
	assign new_free = pop_sum[TW] ? '1 : pop_sum[TW-1:0];
	assign pop_abort = hd_dl_q <= cur_free;
	assign pop_timeout = new_free > hd_dl_q;
	assign pop_delay = (cur_free > hd_arr_q) ? cur_free - hd_arr_q : '0;
	assign head_slot = LW'(cmd.srv * dqd_pkg::QueueDepth) + LW'(head_q[cmd.srv]);

	always_comb begin
		logic [CW:0] t;
		pick = '0;
		pick_ok = 1'b0;
		best_cnt = '0;
		t = '0;
		for (int s = 0; s < dqd_pkg::MaxServers; s++) begin
			if ((s == 0 || !single) && !pick_ok && count_q[s] == '0 &&
				free_q[s] <= job_q.arrival) begin
				pick = SW'(s);
				pick_ok = 1'b1;
			end
		end
		if (!pick_ok) begin
			for (int s = 0; s < dqd_pkg::MaxServers; s++) begin
				if ((s == 0 || !single) && count_q[s] < CW'(dqd_pkg::QueueDepth) &&
					(!pick_ok || count_q[s] < best_cnt)) begin
					pick = SW'(s);
					pick_ok = 1'b1;
					best_cnt = count_q[s];
				end
			end
		end
		t = {1'b0, head_q[pick]} + {1'b0, count_q[pick]};
		if (t >= (CW+1)'(dqd_pkg::QueueDepth)) begin
			t = t - (CW+1)'(dqd_pkg::QueueDepth);
		end
		tail_slot = LW'(pick * dqd_pkg::QueueDepth) + LW'(t);
	end

	always_comb begin
		rec = '0;
		if (cmd.reject) begin
			rec.kind = dqd_pkg::KIND_ABORT;
			rec.job_id = job_q.order_id;
			rec.server = single ? 2'd1 : 2'd0;
			rec.event_time = job_q.arrival;
		end else begin
			rec.kind = pop_abort ? dqd_pkg::KIND_ABORT : dqd_pkg::KIND_TIMEOUT;
			rec.job_id = hd_id_q;
			rec.server = 2'(cmd.srv) + 2'd1;
			rec.delay = pop_delay;
			rec.event_time = pop_abort ? cur_free : new_free;
		end
		rec.last = 1'b0;
	end

	always_comb begin
		pend_out = pend_q;
		pend_out.last = cmd.emit_last;
	end

	assign stat.is_flush = job_q.cmd == dqd_pkg::CMD_FLUSH;
	assign stat.dropped = cmd.place ? !pick_ok : (job_sum > {1'b0, job_q.deadline});
	assign stat.can_serve = count_q[cmd.srv] != '0 &&
		(job_q.cmd == dqd_pkg::CMD_FLUSH || cur_free <= job_q.arrival);
	assign stat.pop_emits = pop_abort || pop_timeout;
	assign stat.out_busy = pend_valid_q && out_valid_q;
	assign stat.single = single;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// A record is held in a pending register so the final one of an item can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= 2'd2;
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int s = 0; s < dqd_pkg::MaxServers; s++) begin
				free_q[s] <= '0;
				head_q[s] <= '0;
				count_q[s] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cnt_cfg_q <= cfg_data;
			end
			if (pend_valid_q && (cmd.emit || cmd.emit_last)) begin
				out_valid_q <= 1'b1;
				out_q <= pend_out;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
				pend_q <= rec;
			end else if (cmd.emit_last) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.pop) begin
				head_q[cmd.srv] <= (head_q[cmd.srv] == PW'(dqd_pkg::QueueDepth - 1)) ?
					'0 : head_q[cmd.srv] + 1'b1;
				count_q[cmd.srv] <= count_q[cmd.srv] - 1'b1;
				if (!pop_abort) begin
					free_q[cmd.srv] <= new_free;
				end
			end
			if (cmd.place && pick_ok) begin
				count_q[pick] <= count_q[pick] + 1'b1;
				if (free_q[pick] < job_q.arrival) begin
					free_q[pick] <= job_q.arrival;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			job_q <= in_data;
		end
		if (cmd.read_head) begin
			hd_id_q <= mem_id[head_slot];
			hd_arr_q <= mem_arr[head_slot];
			hd_dur_q <= mem_dur[head_slot];
			hd_dl_q <= mem_dl[head_slot];
		end
		if (cmd.place && pick_ok) begin
			mem_id[tail_slot] <= job_q.order_id;
			mem_arr[tail_slot] <= job_q.arrival;
			mem_dur[tail_slot] <= job_q.duration;
			mem_dl[tail_slot] <= job_q.deadline;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= CW'(dqd_pkg::QueueDepth))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q[cmd.srv] != '0))
		else $error("pop from empty queue");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled record changed");

endmodule
